// ===== src/bk_pkg.sv =====
`default_nettype none
package bk_pkg;
	localparam int ROOT_ROUNDS   = 7;
	localparam int BRANCH_ROUNDS = 8;
	localparam int MAX_BRANCHES  = 8;
	localparam int KEY_DEPTH     = 16;
	localparam int SLOT_W        = 4;
	localparam int RND_W         = 4;
	localparam int BR_W          = 4;
	localparam int Q_DEPTH       = 2;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_ENCRYPT = 1'b1;

	typedef logic [127:0] blk_t;

	typedef struct packed {
		logic  [BR_W-1:0] count;
		blk_t             msg;
	} job_t;

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[x];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gb(input blk_t s, input int i);
		return s[127-8*i -: 8];
	endfunction

	function automatic blk_t add_key(input blk_t s, input blk_t k, input logic [7:0] tw);
		blk_t r;
		r = s ^ k;
		r[63:32] = r[63:32] ^ {4{tw}};
		return r;
	endfunction

	function automatic blk_t round_fn(input blk_t s);
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, al;
		blk_t r;
		for (int c = 0; c < 4; c++)
			for (int k = 0; k < 4; k++)
				t[4*c+k] = sbox(gb(s, 4*((c+k)%4)+k));
		for (int c = 0; c < 4; c++) begin
			a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
			al = a0 ^ a1 ^ a2 ^ a3;
			r[127-32*c -: 8]    = a0 ^ al ^ xtime(a0 ^ a1);
			r[127-32*c-8 -: 8]  = a1 ^ al ^ xtime(a1 ^ a2);
			r[127-32*c-16 -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
			r[127-32*c-24 -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
		end
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== src/bk_ram.sv =====
`default_nettype none
module bk_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== src/bk_front.sv =====
`default_nettype none
module bk_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 op,
	input  wire logic [3:0]           key_slot,
	input  wire logic [63:0]          word_hi,
	input  wire logic [63:0]          word_lo,
	input  wire logic [3:0]           branch_count,
	output logic                      key_we,
	output logic [bk_pkg::SLOT_W-1:0] key_waddr,
	output bk_pkg::blk_t              key_wdata,
	output logic                      job_valid,
	input  wire logic                 job_take,
	input  wire logic                 eng_busy,
	output bk_pkg::job_t              job
);
	import bk_pkg::*;
	job_t       q_q [Q_DEPTH];
	logic       rd_q, wr_q;
	logic [1:0] cnt_q;
	logic       acc, push;
	logic [BR_W-1:0] cnt_sat;

	// hold any input while the queue is full, and a load until every queued and running message has finished with the keys
	assign in_stall  = (cnt_q == 2'(Q_DEPTH)) ||
		((op == OP_LOAD) && ((cnt_q != 2'd0) || eng_busy));
	assign acc       = in_valid && !in_stall;
	assign push      = acc && (op == OP_ENCRYPT);
	assign key_we    = acc && (op == OP_LOAD);
	assign key_waddr = key_slot;
	assign key_wdata = {word_hi, word_lo};
	assign cnt_sat   = (branch_count > BR_W'(MAX_BRANCHES)) ? BR_W'(MAX_BRANCHES) : branch_count;
	assign job_valid = (cnt_q != 2'd0);
	assign job       = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			q_q[wr_q] <= '{count: cnt_sat, msg: {word_hi, word_lo}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (job_take)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(job_take);
		end
	end
endmodule
`default_nettype wire

// ===== src/bk_back.sv =====
`default_nettype none
module bk_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 job_valid,
	output logic                      job_take,
	input  wire bk_pkg::job_t         job,
	output logic [bk_pkg::SLOT_W-1:0] key_raddr,
	input  wire bk_pkg::blk_t         key_rdata,
	output logic                      eng_busy,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [2:0]                branch_index,
	output logic [63:0]               block_hi,
	output logic [63:0]               block_lo,
	output logic                      last
);
	import bk_pkg::*;
	typedef enum logic [2:0] {IDLE, PRIME, ROOT, BRANCH, FINAL, EMIT} st_t;
	st_t             st_q;
	blk_t            s_q, fork_q;
	logic [RND_W-1:0] rnd_q;
	logic [BR_W-1:0]  br_q, cnt_q;
	logic [7:0]       tw;
	logic [SLOT_W-1:0] ridx;

	assign tw = (st_q == ROOT) ? 8'h00 : 8'(br_q + 1'b1);
	assign job_take = (st_q == IDLE) && job_valid;
	assign eng_busy = (st_q != IDLE);

	always_comb begin
		case (st_q)
			ROOT:    ridx = (rnd_q == RND_W'(ROOT_ROUNDS-1)) ? SLOT_W'(ROOT_ROUNDS) : SLOT_W'(rnd_q + 1'b1);
			BRANCH:  ridx = SLOT_W'(ROOT_ROUNDS + int'(rnd_q) + 1);
			FINAL:   ridx = SLOT_W'(ROOT_ROUNDS + BRANCH_ROUNDS);
			EMIT:    ridx = SLOT_W'(ROOT_ROUNDS);
			default: ridx = '0;
		endcase
	end
	assign key_raddr = ridx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= IDLE;
			rnd_q     <= '0;
			br_q      <= '0;
			cnt_q     <= '0;
			out_valid <= 1'b0;
			last      <= 1'b0;
			branch_index <= '0;
			s_q       <= '0;
			fork_q    <= '0;
			block_hi  <= '0;
			block_lo  <= '0;
		end else begin
			case (st_q)
				IDLE: if (job_valid) begin
					s_q   <= job.msg;
					cnt_q <= job.count;
					rnd_q <= '0;
					br_q  <= '0;
					st_q  <= PRIME;
				end
				PRIME: st_q <= ROOT;
				ROOT: begin
					if (rnd_q == RND_W'(ROOT_ROUNDS-1)) begin
						s_q    <= round_fn(add_key(s_q, key_rdata, tw));
						fork_q <= round_fn(add_key(s_q, key_rdata, tw));
						rnd_q  <= '0;
						st_q   <= (cnt_q == '0) ? IDLE : BRANCH;
					end else begin
						s_q   <= round_fn(add_key(s_q, key_rdata, tw));
						rnd_q <= rnd_q + 1'b1;
					end
				end
				BRANCH: begin
					s_q <= round_fn(add_key(s_q, key_rdata, tw));
					if (rnd_q == RND_W'(BRANCH_ROUNDS-1)) begin
						rnd_q <= '0;
						st_q  <= FINAL;
					end else
						rnd_q <= rnd_q + 1'b1;
				end
				FINAL: if (!out_valid || !out_stall) begin
					{block_hi, block_lo} <= add_key(s_q, key_rdata, tw) ^ fork_q;
					branch_index <= 3'(br_q);
					last      <= (br_q + 1'b1 == cnt_q);
					out_valid <= 1'b1;
					s_q       <= fork_q;
					br_q      <= br_q + 1'b1;
					st_q      <= (br_q + 1'b1 == cnt_q) ? IDLE : EMIT;
				end
				EMIT: st_q <= BRANCH;
				default: st_q <= IDLE;
			endcase
			if (out_valid && !out_stall && !(st_q == FINAL))
				out_valid <= 1'b0;
		end
	end
endmodule
`default_nettype wire

// ===== src/forked_block_cipher_prf_encrypt_top.sv =====
// Forking AES-round cipher with sixteen stored round tweakeys.
// Input channel: in_valid / in_stall, accepted when valid and not stalled.
// op selects a tweakey load (written into slot key_slot, no output) or an
// encryption of {word_hi, word_lo} into branch_count branch blocks (count
// above eight saturates to eight; zero gives no output).
// Output channel: out_valid / out_stall; one transfer per branch with
// branch_index and last marking the final block of a message.
// A two-entry queue decouples intake from the round engine, so new messages
// are taken while one is being worked on; a load is held off until the
// queue and the engine are empty.
// One round per cycle. After its transfer a message passes through queue
// hand-over and key read set-up, seven root rounds, then per branch eight
// rounds, the final add and a key re-read, with no re-read after the last.
// Round keys must be loaded before use; reset clears control and queue.
// A stalled output block holds; the engine waits at the final add.
`default_nettype none
module forked_block_cipher_prf_encrypt_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        op,
	input  wire logic [3:0]  key_slot,
	input  wire logic [63:0] word_hi,
	input  wire logic [63:0] word_lo,
	input  wire logic [3:0]  branch_count,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       branch_index,
	output logic [63:0]      block_hi,
	output logic [63:0]      block_lo,
	output logic             last
);
	import bk_pkg::*;
	logic              key_we, job_valid, job_take, eng_busy;
	logic [SLOT_W-1:0] key_waddr, key_raddr;
	blk_t              key_wdata, key_rdata;
	job_t              job;

	bk_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .op, .key_slot, .word_hi, .word_lo,
		.branch_count, .key_we, .key_waddr, .key_wdata, .job_valid, .job_take,
		.eng_busy, .job
	);

	bk_ram #(.WIDTH(128), .DEPTH(KEY_DEPTH)) u_keys (
		.clk, .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
		.raddr(key_raddr), .rdata(key_rdata)
	);

	bk_back u_back (
		.clk, .arst_n, .job_valid, .job_take, .job, .key_raddr, .key_rdata,
		.eng_busy, .out_valid, .out_stall, .branch_index, .block_hi, .block_lo, .last
	);
endmodule
`default_nettype wire
